>>> src/mma_pkg.sv
// Shared types, register indexes, codes and the measure-width wrap function
// for the masked moment accumulator. No dependencies.
package mma_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_STATS_MASK    = 2'd0;
	localparam logic [1:0] REG_VALUE_TYPE    = 2'd1;
	localparam logic [1:0] REG_ELEMENT_COUNT = 2'd2;

	// Measure widths.
	localparam logic [1:0] VT_BYTE  = 2'd0;
	localparam logic [1:0] VT_SHORT = 2'd1;
	localparam logic [1:0] VT_INT   = 2'd2;
	localparam logic [1:0] VT_LONG  = 2'd3;

	// Result codes.
	localparam logic [2:0] CODE_COUNT = 3'd0;
	localparam logic [2:0] CODE_SUM1  = 3'd1;
	localparam logic [2:0] CODE_SUM2  = 3'd2;
	localparam logic [2:0] CODE_SUM3  = 3'd3;
	localparam logic [2:0] CODE_SUM4  = 3'd4;
	localparam logic [2:0] CODE_MAX   = 3'd5;
	localparam logic [2:0] CODE_MIN   = 3'd6;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POW,
		ST_UPDATE,
		ST_EMIT
	} mma_state_t;

	// One row of the per-element partial store.
	typedef struct packed {
		logic [63:0] s1;
		logic [63:0] s2;
		logic [63:0] s3;
		logic [63:0] s4;
		logic [63:0] mx;
		logic [63:0] mn;
	} stat_row_t;

	// Start request to the power unit.
	typedef struct packed {
		logic       start;
		logic [1:0] npow;
	} mma_pow_req_t;

	// Truncate to the measure width and sign-extend back to 64 bits.
	function automatic logic [63:0] fit(input logic [63:0] v, input logic [1:0] vt);
		logic [63:0] r;
		case (vt)
			VT_BYTE:  r = {{56{v[7]}}, v[7:0]};
			VT_SHORT: r = {{48{v[15]}}, v[15:0]};
			VT_INT:   r = {{32{v[31]}}, v[31:0]};
			default:  r = v;
		endcase
		return r;
	endfunction

endpackage

>>> src/masked_moment_accumulator.sv
// Add: ready again once the P = 0..3 powers of x that the mask needs have each passed
// the shared 32x32 multiplier in turn and the updated row has been written back.
// Read: N = 1..7 results, one a cycle unless rsp_ready stalls, each from the output register.
// Clear, unused kinds and adds with nothing to store keep the block in idle.
// Reset: asynchronous, active low; clears control, row count and configuration
// (mask 1, int measure, one element); the partial store is not cleared.
// Depends on mma_pkg, mma_pow_unit and mma_stat_mem.
module masked_moment_accumulator #(
	parameter int NUM_ELEMS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Request channel
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         kind,
	input  logic [7:0]         elem_index,
	input  logic signed [63:0] sample,
	input  logic               row_end,
	// Result channel
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic signed [63:0] stat_value,
	output logic [2:0]         stat_code,
	output logic               null_result,
	output logic               error_flag,
	output logic               last
);

	localparam int IDX_W = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;
	localparam logic [16:0] NUM_ELEMS_V = 17'(NUM_ELEMS);

	// Configuration registers.
	logic [6:0] stats_mask_q;
	logic [1:0] value_type_q;
	logic [8:0] element_count_q;

	// Control and payload registers.
	mma_pkg::mma_state_t state_q, state_d;
	logic [31:0]      row_count_q, row_count_d;
	logic [63:0]      x_q;
	logic [IDX_W-1:0] idx_q;
	logic             row_end_q;
	logic             first_q;
	logic [6:0]       rem_q, rem_d;
	logic             null_q, err_q;

	// Output register.
	logic        rsp_valid_q;
	logic [63:0] stat_value_q;
	logic [2:0]  stat_code_q;
	logic        null_result_q, error_flag_q, last_q;

	logic             k1, k2, k3, k4, kmax, kmin;
	logic             req_fire, cfg_wr, inrange, load_out, mem_we;
	logic [16:0]      idx_ext;
	logic [IDX_W-1:0] in_addr;
	logic [1:0]       npow;
	logic [6:0]       pick;
	logic [2:0]       code;
	logic [63:0]      out_val;
	logic [63:0]      x2, x3, x4;
	logic             pow_done;
	mma_pkg::mma_pow_req_t pow_req;
	mma_pkg::stat_row_t    rd_row, wr_row;

	// Which partials the mask keeps.
	assign k1   = |stats_mask_q[4:0];
	assign k2   = |stats_mask_q[4:1];
	assign k3   = |stats_mask_q[4:3];
	assign k4   = stats_mask_q[4];
	assign kmax = stats_mask_q[5];
	assign kmin = stats_mask_q[6];
	assign npow = k4 ? 2'd3 : (k3 ? 2'd2 : (k2 ? 2'd1 : 2'd0));

	// Element range check against both the configured count and the store depth.
	assign idx_ext = 17'(elem_index);
	assign in_addr = idx_ext[IDX_W-1:0];
	assign inrange = ({1'b0, elem_index} < element_count_q) && (idx_ext < NUM_ELEMS_V);

	assign req_ready = (state_q == mma_pkg::ST_IDLE);
	assign req_fire  = req_valid && req_ready;

	// Configuration writes and reads.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_mask_q    <= 7'd1;
			value_type_q    <= mma_pkg::VT_INT;
			element_count_q <= 9'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				mma_pkg::REG_STATS_MASK:    stats_mask_q    <= pwdata[6:0];
				mma_pkg::REG_VALUE_TYPE:    value_type_q    <= pwdata[1:0];
				mma_pkg::REG_ELEMENT_COUNT: element_count_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			mma_pkg::REG_STATS_MASK:    prdata = {25'd0, stats_mask_q};
			mma_pkg::REG_VALUE_TYPE:    prdata = {30'd0, value_type_q};
			mma_pkg::REG_ELEMENT_COUNT: prdata = {23'd0, element_count_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// Shared power unit.
	mma_pow_unit u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pow_req),
		.x      (x_q),
		.vtype  (value_type_q),
		.done   (pow_done),
		.x2     (x2),
		.x3     (x3),
		.x4     (x4)
	);

	// Partial store, read at every accepted request.
	mma_stat_mem #(
		.DEPTH (NUM_ELEMS),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_q),
		.wdata (wr_row),
		.re    (req_fire),
		.raddr (in_addr),
		.rdata (rd_row)
	);

	// New row: first row of a group loads, later rows add or compare.
	always_comb begin
		wr_row = rd_row;
		if (k1) begin
			wr_row.s1 = first_q ? x_q : mma_pkg::fit(rd_row.s1 + x_q, value_type_q);
		end
		if (k2) begin
			wr_row.s2 = first_q ? x2 : mma_pkg::fit(rd_row.s2 + x2, value_type_q);
		end
		if (k3) begin
			wr_row.s3 = first_q ? x3 : mma_pkg::fit(rd_row.s3 + x3, value_type_q);
		end
		if (k4) begin
			wr_row.s4 = first_q ? x4 : mma_pkg::fit(rd_row.s4 + x4, value_type_q);
		end
		if (kmax && (first_q || $signed(x_q) > $signed(rd_row.mx))) begin
			wr_row.mx = x_q;
		end
		if (kmin && (first_q || $signed(rd_row.mn) > $signed(x_q))) begin
			wr_row.mn = x_q;
		end
	end

	// Next result: lowest pending code.
	assign pick = rem_q & (~rem_q + 7'd1);

	always_comb begin
		code = mma_pkg::CODE_COUNT;
		for (int i = 6; i >= 0; i--) begin
			if (rem_q[i]) begin
				code = 3'(i);
			end
		end
	end

	always_comb begin
		case (code)
			mma_pkg::CODE_SUM1: out_val = mma_pkg::fit(rd_row.s1, value_type_q);
			mma_pkg::CODE_SUM2: out_val = mma_pkg::fit(rd_row.s2, value_type_q);
			mma_pkg::CODE_SUM3: out_val = mma_pkg::fit(rd_row.s3, value_type_q);
			mma_pkg::CODE_SUM4: out_val = mma_pkg::fit(rd_row.s4, value_type_q);
			mma_pkg::CODE_MAX:  out_val = mma_pkg::fit(rd_row.mx, value_type_q);
			mma_pkg::CODE_MIN:  out_val = mma_pkg::fit(rd_row.mn, value_type_q);
			default:            out_val = (null_q || err_q) ? 64'd0 : {32'd0, row_count_q};
		endcase
	end

	// Sequencer: next state and control.
	always_comb begin
		state_d       = state_q;
		row_count_d   = row_count_q;
		rem_d         = rem_q;
		load_out      = 1'b0;
		mem_we        = 1'b0;
		pow_req.start = 1'b0;
		pow_req.npow  = npow;
		case (state_q)
			mma_pkg::ST_IDLE: begin
				if (req_fire) begin
					case (kind)
						mma_pkg::KIND_CLEAR: begin
							row_count_d = 32'd0;
						end
						mma_pkg::KIND_ADD: begin
							if (stats_mask_q != 7'd0) begin
								if (!inrange) begin
									row_count_d = row_count_q + 32'(row_end);
								end else if (npow != 2'd0) begin
									pow_req.start = 1'b1;
									state_d = mma_pkg::ST_POW;
								end else begin
									state_d = mma_pkg::ST_UPDATE;
								end
							end
						end
						mma_pkg::KIND_READ: begin
							if (stats_mask_q == 7'd0 || row_count_q == 32'd0 || !inrange) begin
								rem_d = 7'b0000001;
							end else begin
								rem_d = {kmin, kmax, k4, k3, k2, k1, 1'b1};
							end
							state_d = mma_pkg::ST_EMIT;
						end
						default: ;
					endcase
				end
			end
			mma_pkg::ST_POW: begin
				if (pow_done) begin
					state_d = mma_pkg::ST_UPDATE;
				end
			end
			mma_pkg::ST_UPDATE: begin
				mem_we      = 1'b1;
				row_count_d = row_count_q + 32'(row_end_q);
				state_d     = mma_pkg::ST_IDLE;
			end
			mma_pkg::ST_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_out = 1'b1;
					rem_d    = rem_q & ~pick;
					if (rem_d == 7'd0) begin
						state_d = mma_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = mma_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mma_pkg::ST_IDLE;
			row_count_q <= 32'd0;
			rem_q       <= 7'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_count_q <= row_count_d;
			rem_q       <= rem_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request payload captured at each accepted transfer.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			x_q       <= mma_pkg::fit(sample, value_type_q);
			idx_q     <= in_addr;
			row_end_q <= row_end;
			first_q   <= (row_count_q == 32'd0);
			err_q     <= (stats_mask_q == 7'd0);
			null_q    <= (stats_mask_q != 7'd0) && (row_count_q == 32'd0 || !inrange);
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			stat_value_q  <= out_val;
			stat_code_q   <= code;
			null_result_q <= null_q;
			error_flag_q  <= err_q;
			last_q        <= (rem_d == 7'd0);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign stat_value  = stat_value_q;
	assign stat_code   = stat_code_q;
	assign null_result = null_result_q;
	assign error_flag  = error_flag_q;
	assign last        = last_q;

endmodule

>>> src/mma_stat_mem.sv
// Per-element partial store: one row of six 64-bit partials per element.
// Depends on mma_pkg for the row type.
module mma_stat_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  mma_pkg::stat_row_t wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output mma_pkg::stat_row_t rdata
);

	mma_pkg::stat_row_t mem [DEPTH];
	mma_pkg::stat_row_t rdata_q;

	// Single write port and a registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/mma_pow_unit.sv
// Power unit: forms x^2, x^3 and x^4, wrapped to the measure width, with one shared 32x32
// multiplier, three partial products per power. Depends on mma_pkg.
module mma_pow_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mma_pkg::mma_pow_req_t req,
	input  logic [63:0]          x,
	input  logic [1:0]           vtype,
	output logic                 done,
	output logic [63:0]          x2,
	output logic [63:0]          x3,
	output logic [63:0]          x4
);

	logic        busy_q;
	logic [1:0]  step_q;
	logic [1:0]  pow_q;
	logic [1:0]  npow_q;
	logic [63:0] cur_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [63:0] x2_q, x3_q, x4_q;
	logic [63:0] a_op;
	logic [31:0] mul_a, mul_b;
	logic [63:0] res;

	// The first power multiplies x by itself, later ones the previous power.
	assign a_op = (pow_q == 2'd0) ? x : cur_q;

	// Operand selection for the three partial products that reach the low 64 bits.
	always_comb begin
		case (step_q)
			2'd1: begin
				mul_a = a_op[31:0];
				mul_b = x[63:32];
			end
			2'd2: begin
				mul_a = a_op[63:32];
				mul_b = x[31:0];
			end
			default: begin
				mul_a = a_op[31:0];
				mul_b = x[31:0];
			end
		endcase
	end

	assign res  = mma_pkg::fit(acc_q + {prod_q[31:0], 32'h0}, vtype);
	assign done = busy_q && (step_q == 2'd3) && (pow_q == npow_q - 2'd1);

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			pow_q  <= 2'd0;
			npow_q <= 2'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= 2'd0;
			pow_q  <= 2'd0;
			npow_q <= req.npow;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			if (step_q == 2'd3) begin
				pow_q <= pow_q + 2'd1;
				if (done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Multiply, then accumulate the registered product in the next cycle.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (step_q)
			2'd1: acc_q <= prod_q;
			2'd2: acc_q <= acc_q + {prod_q[31:0], 32'h0};
			default: acc_q <= acc_q;
		endcase
		if (busy_q && step_q == 2'd3) begin
			cur_q <= res;
			case (pow_q)
				2'd0: x2_q <= res;
				2'd1: x3_q <= res;
				default: x4_q <= res;
			endcase
		end
	end

	assign x2 = x2_q;
	assign x3 = x3_q;
	assign x4 = x4_q;

endmodule

>>> src/mma_checker.sv
// Port-level checks for the masked moment accumulator result channel,
// bound to the top level. Depends on mma_pkg and masked_moment_accumulator's ports.
module mma_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [63:0] stat_value,
	input logic [2:0]         stat_code,
	input logic               null_result,
	input logic               error_flag,
	input logic               last
);

	// A stalled result transfer stays valid and holds its value, code and last flag.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(stat_value) && $stable(stat_code)
		&& $stable(last))
		else $error("result changed while stalled");

	// An error result stands alone and carries nothing.
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error_flag |-> last && !null_result && stat_code == mma_pkg::CODE_COUNT
		&& stat_value == 64'sd0)
		else $error("malformed error result");

	// A null result stands alone and carries nothing.
	a_null_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && null_result |-> last && stat_code == mma_pkg::CODE_COUNT
		&& stat_value == 64'sd0)
		else $error("malformed null result");

	// Partials only come in a normal read run, and codes stay in range.
	a_code_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && stat_code != mma_pkg::CODE_COUNT |-> !null_result && !error_flag
		&& stat_code != 3'd7)
		else $error("bad partial result code");

endmodule

bind masked_moment_accumulator mma_checker u_mma_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.stat_value  (stat_value),
	.stat_code   (stat_code),
	.null_result (null_result),
	.error_flag  (error_flag),
	.last        (last)
);

>>> tb/tb.sv
// Self-checking testbench for masked_moment_accumulator: random and directed request
// transfers, a scoreboard class that predicts every result, and APB register writes.
// Depends on mma_pkg and the masked_moment_accumulator RTL.
`timescale 1ns / 100ps

module tb;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 12;
	localparam int ITEM_TARGET = 310;
	localparam int SETTLE_CYCLES = 20;
	localparam int IDLE_LIMIT = 2000;

	// One result transfer as the block should present it.
	typedef struct packed {
		logic [63:0] value;
		logic [2:0]  code;
		logic        null_result;
		logic        error_flag;
		logic        last;
	} stat_result_t;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_PERIODIC,
		RDY_SPARSE
	} ready_mode_t;

	// Mirror of the accumulator: configuration, row count, partial store and the
	// queue of statistics that the block still owes.
	class moment_tracker;
		stat_result_t expected_stats[$];
		int unsigned  fail_count;
		logic [6:0]   stats_mask;
		logic [1:0]   value_type;
		logic [8:0]   element_count;
		logic [31:0]  row_count;
		// Partials 0..5: sum x, sum x^2, sum x^3, sum x^4, max, min.
		logic [63:0]  partial [0:5][0:255];
		bit           loaded [0:5][0:255];

		function new();
			fail_count = 0;
			stats_mask = 7'd1;
			value_type = mma_pkg::VT_INT;
			element_count = 9'd1;
			row_count = '0;
		endfunction

		function int unsigned pending();
			return expected_stats.size();
		endfunction

		function void set_register(input logic [1:0] ridx, input logic [31:0] v);
			case (ridx)
				mma_pkg::REG_STATS_MASK:    stats_mask = v[6:0];
				mma_pkg::REG_VALUE_TYPE:    value_type = v[1:0];
				mma_pkg::REG_ELEMENT_COUNT: element_count = v[8:0];
				default: ;
			endcase
		endfunction

		// Wrap to the measure width and sign-extend back to 64 bits.
		function logic [63:0] to_measure(input logic [63:0] v);
			int sh;
			sh = 64 - (8 << value_type);
			return 64'($signed(v << sh) >>> sh);
		endfunction

		// Whether the current mask keeps the given partial.
		function bit keeps(input int p);
			case (p)
				0:       return |stats_mask[4:0];
				1:       return |stats_mask[4:1];
				2:       return |stats_mask[4:3];
				3:       return stats_mask[4];
				4:       return stats_mask[5];
				default: return stats_mask[6];
			endcase
		endfunction

		function int in_use();
			return (element_count > 9'd256) ? 256 : int'(element_count);
		endfunction

		// True when the request would make the block read a partial that was
		// never loaded since reset.
		function bit touches_unwritten(input logic [1:0] k, input logic [7:0] idx);
			if ((k != mma_pkg::KIND_ADD && k != mma_pkg::KIND_READ) || stats_mask == '0
					|| row_count == '0 || idx >= in_use())
				return 1'b0;
			for (int p = 0; p < 6; p++) begin
				if (keeps(p) && !loaded[p][idx])
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void expect_result(input logic [63:0] v, input logic [2:0] c,
				input logic nul, input logic err, input logic fin);
			stat_result_t r;
			r.value = v;
			r.code = c;
			r.null_result = nul;
			r.error_flag = err;
			r.last = fin;
			expected_stats.push_back(r);
		endfunction

		// Apply one accepted request and queue the statistics it produces.
		function void note_request(input logic [1:0] k, input logic [7:0] idx,
				input logic [63:0] smp, input logic re);
			logic [63:0] pw [0:3];
			logic [63:0] x;
			bit first;
			int final_p;
			case (k)
				mma_pkg::KIND_CLEAR: row_count = '0;
				mma_pkg::KIND_ADD: begin
					if (stats_mask != '0) begin
						if (idx < in_use()) begin
							first = (row_count == '0);
							x = to_measure(smp);
							pw[0] = x;
							for (int i = 1; i < 4; i++)
								pw[i] = to_measure(pw[i-1] * x);
							for (int p = 0; p < 4; p++) begin
								if (keeps(p)) begin
									partial[p][idx] = first ? pw[p]
										: to_measure(partial[p][idx] + pw[p]);
									loaded[p][idx] = 1'b1;
								end
							end
							if (keeps(4) && (first || $signed(x) > $signed(partial[4][idx]))) begin
								partial[4][idx] = x;
								loaded[4][idx] = 1'b1;
							end
							if (keeps(5) && (first || $signed(partial[5][idx]) > $signed(x))) begin
								partial[5][idx] = x;
								loaded[5][idx] = 1'b1;
							end
						end
						if (re)
							row_count = row_count + 32'd1;
					end
				end
				mma_pkg::KIND_READ: begin
					// A zero mask wins over an empty group.
					if (stats_mask == '0) begin
						expect_result('0, mma_pkg::CODE_COUNT, 1'b0, 1'b1, 1'b1);
					end else if (row_count == '0 || idx >= in_use()) begin
						expect_result('0, mma_pkg::CODE_COUNT, 1'b1, 1'b0, 1'b1);
					end else begin
						final_p = 0;
						for (int p = 0; p < 6; p++) begin
							if (keeps(p))
								final_p = p;
						end
						expect_result({32'd0, row_count}, mma_pkg::CODE_COUNT, 1'b0, 1'b0,
							1'b0);
						for (int p = 0; p < 6; p++) begin
							if (keeps(p))
								expect_result(to_measure(partial[p][idx]),
									mma_pkg::CODE_SUM1 + 3'(p), 1'b0, 1'b0, p == final_p);
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			fail_count++;
		endtask

		// Compare one result transfer with the oldest expected statistic.
		task check_result(input logic [63:0] v, input logic [2:0] c, input logic nul,
				input logic err, input logic fin);
			stat_result_t e;
			if (expected_stats.size() == 0) begin
				report_mismatch($sformatf("result %h code %0d with nothing expected", v, c));
			end else begin
				e = expected_stats.pop_front();
				if (v !== e.value)
					report_mismatch($sformatf("stat_value %h, expected %h (code %0d)",
						v, e.value, e.code));
				if (c !== e.code)
					report_mismatch($sformatf("stat_code %0d, expected %0d", c, e.code));
				if (nul !== e.null_result)
					report_mismatch($sformatf("null_result %b, expected %b", nul, e.null_result));
				if (err !== e.error_flag)
					report_mismatch($sformatf("error_flag %b, expected %b", err, e.error_flag));
				if (fin !== e.last)
					report_mismatch($sformatf("last %b, expected %b (code %0d)", fin, e.last,
						e.code));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_ready;
	logic [1:0]         kind = mma_pkg::KIND_ADD;
	logic [7:0]         elem_index = '0;
	logic signed [63:0] sample = '0;
	logic               row_end = 1'b0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic signed [63:0] stat_value;
	logic [2:0]         stat_code;
	logic               null_result;
	logic               error_flag;
	logic               last;

	moment_tracker tracker;
	int            items_sent = 0;
	int            burst_left = 0;
	int            idle_cycles = 0;
	ready_mode_t   ready_mode = RDY_ALWAYS;
	int            mode_left = 0;
	logic [3:0]    ready_phase = '0;

	masked_moment_accumulator #(
		.NUM_ELEMS(256)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.kind       (kind),
		.elem_index (elem_index),
		.sample     (sample),
		.row_end    (row_end),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.stat_value (stat_value),
		.stat_code  (stat_code),
		.null_result(null_result),
		.error_flag (error_flag),
		.last       (last)
	);

	// Free-running clock.
	always #CLK_HALF clk = ~clk;

	// Receiver readiness: switches at random between stall patterns.
	always @(posedge clk) begin
		ready_phase <= ready_phase + 4'd1;
		if (mode_left == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(16, 96);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			RDY_ALWAYS:   rsp_ready <= 1'b1;
			RDY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
			RDY_PERIODIC: rsp_ready <= (ready_phase[2:0] < 3'd3);
			default:      rsp_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Check every result transfer against the scoreboard.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_result(stat_value, stat_code, null_result, error_flag, last);
	end

	// Watchdog: too long without any transfer ends the run.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Random sample, mostly shaped to the current measure width.
	function automatic logic [63:0] pick_sample();
		logic [63:0] raw;
		int w;
		w = 8 << tracker.value_type;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return (w == 64) ? 64'h7FFF_FFFF_FFFF_FFFF : (64'd1 << (w - 1)) - 64'd1;
			3: return (w == 64) ? 64'h8000_0000_0000_0000 : ~((64'd1 << (w - 1)) - 64'd1);
			4: return raw;
			5: return {{60{raw[3]}}, raw[3:0]};
			default: return tracker.to_measure(raw);
		endcase
	endfunction

	// Send one request transfer; the sender works in bursts with gaps between them.
	task automatic send_req(input logic [1:0] k, input logic [7:0] idx,
			input logic [63:0] smp, input logic re);
		logic [1:0] k_use;
		int gap;
		// Never let the block read a partial that was never loaded.
		k_use = tracker.touches_unwritten(k, idx) ? mma_pkg::KIND_CLEAR : k;
		if (burst_left <= 0) begin
			req_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		req_valid <= 1'b1;
		kind <= k_use;
		elem_index <= idx;
		sample <= smp;
		row_end <= re;
		do @(posedge clk); while (!(req_valid && req_ready));
		tracker.note_request(k_use, idx, smp, re);
		burst_left--;
		items_sent++;
	endtask

	// Hold off the sender until every expected result has arrived, then let the
	// block finish any add that is still in flight.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value at
	// the edge that closes the access cycle.
	task automatic write_reg(input logic [1:0] ridx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {ridx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		tracker.set_register(ridx, v);
	endtask

	initial begin : stimulus
		logic [7:0] members[$];
		logic [7:0] row_list[$];
		logic [7:0] idx;
		int n_use;
		int rows;
		tracker = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Empty group under the reset configuration.
		send_req(mma_pkg::KIND_READ, 8'd0, '0, 1'b0);

		// Zero mask: a read flags an error even with an empty group, an add does nothing.
		wait_drained();
		write_reg(mma_pkg::REG_STATS_MASK, 32'h0);
		send_req(mma_pkg::KIND_READ, 8'd0, '0, 1'b0);
		send_req(mma_pkg::KIND_ADD, 8'd0, 64'd5, 1'b1);

		// Full mask, 64-bit measure, four elements: extremes and wrap of the sums.
		wait_drained();
		write_reg(mma_pkg::REG_STATS_MASK, 32'h7F);
		write_reg(mma_pkg::REG_VALUE_TYPE, {30'd0, mma_pkg::VT_LONG});
		write_reg(mma_pkg::REG_ELEMENT_COUNT, 32'd4);
		send_req(mma_pkg::KIND_ADD, 8'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		send_req(mma_pkg::KIND_ADD, 8'd1, 64'h8000_0000_0000_0000, 1'b0);
		send_req(mma_pkg::KIND_ADD, 8'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_req(mma_pkg::KIND_ADD, 8'd3, 64'd3, 1'b1);
		// Out-of-range element still closes its row.
		send_req(mma_pkg::KIND_ADD, 8'd200, 64'd7, 1'b1);
		send_req(mma_pkg::KIND_ADD, 8'd1, 64'h4000_0000_0000_0001, 1'b0);
		send_req(mma_pkg::KIND_READ, 8'd0, '0, 1'b0);
		send_req(mma_pkg::KIND_READ, 8'd1, '0, 1'b0);
		send_req(mma_pkg::KIND_READ, 8'd3, '0, 1'b0);
		send_req(mma_pkg::KIND_READ, 8'd255, '0, 1'b0);
		send_req(2'd3, 8'd0, '0, 1'b1);
		send_req(mma_pkg::KIND_CLEAR, 8'd0, '0, 1'b0);
		send_req(mma_pkg::KIND_READ, 8'd0, '0, 1'b0);

		// Byte measure, max and min only, all elements in use.
		wait_drained();
		write_reg(mma_pkg::REG_VALUE_TYPE, {30'd0, mma_pkg::VT_BYTE});
		write_reg(mma_pkg::REG_STATS_MASK, 32'h60);
		write_reg(mma_pkg::REG_ELEMENT_COUNT, 32'd256);
		send_req(mma_pkg::KIND_ADD, 8'd255, 64'h80, 1'b0);
		send_req(mma_pkg::KIND_ADD, 8'd128, 64'h17F, 1'b1);
		send_req(mma_pkg::KIND_ADD, 8'd255, 64'h7F, 1'b1);
		send_req(mma_pkg::KIND_READ, 8'd255, '0, 1'b0);

		// Mask narrowed inside the group.
		wait_drained();
		write_reg(mma_pkg::REG_STATS_MASK, 32'h20);
		send_req(mma_pkg::KIND_READ, 8'd255, '0, 1'b0);

		// No element in use.
		wait_drained();
		write_reg(mma_pkg::REG_ELEMENT_COUNT, 32'd0);
		send_req(mma_pkg::KIND_ADD, 8'd0, 64'd1, 1'b1);
		send_req(mma_pkg::KIND_READ, 8'd0, '0, 1'b0);

		// Random phases: a new setting, then a group of rows and reads, or noise.
		while (items_sent < ITEM_TARGET) begin
			wait_drained();
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 7))
					0:       write_reg(mma_pkg::REG_STATS_MASK, 32'h0);
					1:       write_reg(mma_pkg::REG_STATS_MASK, 32'h7F);
					2:       write_reg(mma_pkg::REG_STATS_MASK, 32'h01);
					3:       write_reg(mma_pkg::REG_STATS_MASK, 32'h10);
					4:       write_reg(mma_pkg::REG_STATS_MASK, 32'h60);
					default: write_reg(mma_pkg::REG_STATS_MASK, $urandom_range(1, 127));
				endcase
			end
			if ($urandom_range(0, 1) == 0)
				write_reg(mma_pkg::REG_VALUE_TYPE, $urandom_range(0, 3));
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0:       write_reg(mma_pkg::REG_ELEMENT_COUNT, 32'd0);
					1:       write_reg(mma_pkg::REG_ELEMENT_COUNT, 32'd256);
					2:       write_reg(mma_pkg::REG_ELEMENT_COUNT, 32'd511);
					3:       write_reg(mma_pkg::REG_ELEMENT_COUNT, $urandom_range(9, 511));
					default: write_reg(mma_pkg::REG_ELEMENT_COUNT, $urandom_range(1, 8));
				endcase
			end
			n_use = tracker.in_use();

			if ($urandom_range(0, 4) == 0) begin
				// Noise: any kind, any element, any payload.
				repeat ($urandom_range(3, 8))
					send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						{$urandom, $urandom}, 1'($urandom_range(0, 1)));
			end else begin
				// Well-formed group: usually a clear, rows over a set of elements, reads.
				if ($urandom_range(0, 9) != 0)
					send_req(mma_pkg::KIND_CLEAR, 8'($urandom), pick_sample(), 1'($urandom));
				members.delete();
				if (n_use == 0) begin
					members.push_back(8'($urandom));
				end else if (n_use <= 8) begin
					for (int e = 0; e < n_use; e++)
						members.push_back(8'(e));
				end else begin
					repeat ($urandom_range(1, 5))
						members.push_back(8'($urandom_range(0, n_use - 1)));
					if ($urandom_range(0, 2) == 0)
						members.push_back(8'(n_use - 1));
				end
				rows = $urandom_range(1, 4);
				for (int r = 0; r < rows; r++) begin
					row_list.delete();
					foreach (members[m]) begin
						if (r == 0 || $urandom_range(0, 3) != 0)
							row_list.push_back(members[m]);
					end
					if (row_list.size() == 0)
						row_list.push_back(members[0]);
					if (n_use < 256 && $urandom_range(0, 7) == 0)
						send_req(mma_pkg::KIND_ADD, 8'($urandom_range(n_use, 255)),
							pick_sample(), 1'b0);
					foreach (row_list[q])
						send_req(mma_pkg::KIND_ADD, row_list[q], pick_sample(),
							q == row_list.size() - 1);
				end
				if ($urandom_range(0, 5) == 0)
					wait_drained();
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 4) == 0)
						idx = 8'($urandom_range(0, 255));
					else
						idx = members[$urandom_range(0, members.size() - 1)];
					send_req(mma_pkg::KIND_READ, idx, pick_sample(), 1'($urandom));
				end
			end
		end

		wait_drained();
		if (tracker.fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> masked_moment_accumulator.f
src/mma_pkg.sv
src/mma_stat_mem.sv
src/mma_pow_unit.sv
src/masked_moment_accumulator.sv
src/mma_checker.sv
tb/tb.sv
